// File: src/dsq_pkg.sv
// ----------------------------------------------------------------------------
// dsq_pkg: shared types and codes of the delta sleep queue
// Word layouts of both channels, command and link structs between the top
// level and the cells, and the operation and result codes.
// ----------------------------------------------------------------------------
package dsq_pkg;

  // Default number of list positions.
  localparam int unsigned DepthDef = 16;

  localparam int unsigned TidW   = 8;
  localparam int unsigned TicksW = 16;

  // Operation codes of an input word.
  localparam logic [1:0] FuncInsert  = 2'd0;
  localparam logic [1:0] FuncTick    = 2'd1;
  localparam logic [1:0] FuncUnblock = 2'd2;

  // Result kinds.
  localparam logic [1:0] KindReleased = 2'd0;
  localparam logic [1:0] KindAccepted = 2'd1;
  localparam logic [1:0] KindRefused  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [TidW-1:0]   thread_id;
    logic [TicksW-1:0] sleep_ticks;
  } in_word_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [TidW-1:0] thread_id_res;
    logic            last;
  } out_word_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic [TidW-1:0]   thr;  // Thread id held.
    logic [TicksW-1:0] dlt;  // Delta held.
    logic              blk;  // Blocked mark held.
    logic              tok;  // The search token sits here.
    logic [TicksW-1:0] rem;  // Remaining sleep carried by the token.
    logic              fwd;  // The token moves on to the right.
    logic [TicksW-1:0] rnx;  // Remaining sleep handed to the right.
  } link_t;

  // Commands broadcast from the sequencer to every cell.
  typedef struct packed {
    logic            start;     // A search begins at the head.
    logic            ins_mode;  // The search is for an insert.
    logic            ins_go;    // The insert position is found this cycle.
    logic            pop;       // Every entry moves one place to the left.
    logic [TidW-1:0] tid;       // Thread id of the current word.
  } cmd_t;

endpackage

// File: src/dsq_cell.sv
// ----------------------------------------------------------------------------
// dsq_cell: one position of the delta list
// Holds one entry and a search token, and trades entries with its neighbors
// on inserts and pops.
// ----------------------------------------------------------------------------
module dsq_cell (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           occ_i,
  input  logic           head_dec_i,
  input  dsq_pkg::cmd_t  cmd_i,
  input  dsq_pkg::link_t left_i,
  input  dsq_pkg::link_t right_i,
  output dsq_pkg::link_t link_o
);

  logic [dsq_pkg::TidW-1:0]   thr_q, thr_d;
  logic [dsq_pkg::TicksW-1:0] dlt_q, dlt_d;
  logic                       blk_q, blk_d;
  logic [dsq_pkg::TicksW-1:0] rem_q, rem_d;
  logic                       tok_q, tok_d;
  logic                       ahead_q, ahead_d;
  logic                       less, match, fwd, hit;

  assign less  = dlt_q < rem_q;
  assign match = thr_q == cmd_i.tid;
  assign fwd   = tok_q & occ_i & (cmd_i.ins_mode ? less : ~match);
  assign hit   = tok_q & occ_i & ~cmd_i.ins_mode & match;

  assign link_o = '{thr: thr_q, dlt: dlt_q, blk: blk_q, tok: tok_q, rem: rem_q,
                    fwd: fwd, rnx: rem_q - dlt_q};

  always_comb begin
    tok_d   = left_i.fwd;
    rem_d   = left_i.rnx;
    ahead_d = cmd_i.start ? 1'b1 : (ahead_q & ~fwd);
    thr_d   = thr_q;
    dlt_d   = dlt_q;
    blk_d   = blk_q;
    if (cmd_i.pop) begin
      thr_d = right_i.thr;
      dlt_d = right_i.dlt;
      blk_d = right_i.blk;
    end else if (cmd_i.ins_go) begin
      if (tok_q) begin
        thr_d = cmd_i.tid;
        dlt_d = rem_q;
        blk_d = 1'b1;
      end else if (ahead_q) begin
        // The entry that was at the insert point gets its delta lowered.
        thr_d = left_i.thr;
        blk_d = left_i.blk;
        dlt_d = left_i.tok ? (left_i.dlt - left_i.rem) : left_i.dlt;
      end
    end else if (hit) begin
      blk_d = 1'b0;
    end else if (head_dec_i) begin
      dlt_d = dlt_q - {{(dsq_pkg::TicksW-1){1'b0}}, (dlt_q != '0)};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q   <= 1'b0;
      ahead_q <= 1'b0;
    end else begin
      tok_q   <= tok_d;
      ahead_q <= ahead_d;
    end
  end

  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
    dlt_q <= dlt_d;
    blk_q <= blk_d;
    rem_q <= rem_d;
  end

endmodule

// File: src/delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// delta_sleep_queue: timer queue of sleeping threads kept as a delta list
// A row of cells holds the list; a small sequencer drives searches, inserts,
// ticks and pops, and a one-word output register feeds the result channel.
// ----------------------------------------------------------------------------
// The block takes one input word at a time and holds in_stall_o high until
// that word is finished. An insert into a list that is not full walks a
// token from the head one cell per cycle past every entry whose delta is
// smaller than what is left of the sleep, then hands its single result to
// the output register once that is free; an insert into a full list skips
// the walk and is refused. An unblock walks the same way up to the matching
// entry, or over the whole fill level when there is none; it returns no word.
// A tick decrements the head delta, then pops every head entry at zero in
// turn, waiting while the output side stalls. Results of one input leave in
// order, the final one marked by last; a tick on an empty queue, an unblock
// and an unused function code return nothing.
// ----------------------------------------------------------------------------
module delta_sleep_queue #(
  parameter int unsigned Depth = dsq_pkg::DepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dsq_pkg::in_word_t   in_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output dsq_pkg::out_word_t  out_o
);

  localparam int unsigned CntW = $clog2(Depth + 1);

  // Sequencer states.
  localparam logic [1:0] SIdle = 2'd0;
  localparam logic [1:0] SWalk = 2'd1;
  localparam logic [1:0] SResp = 2'd2;
  localparam logic [1:0] SPop  = 2'd3;

  logic [1:0]                 state_q, state_d;
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic                       ins_mode_q, ins_mode_d;
  logic [dsq_pkg::TidW-1:0]   tid_q, tid_d;
  logic [1:0]                 kind_q, kind_d;
  logic                       pend_v_q, pend_v_d;
  logic [dsq_pkg::TidW-1:0]   pend_id_q, pend_id_d;
  logic                       out_valid_q, out_valid_d;
  dsq_pkg::out_word_t         out_q, out_d;

  dsq_pkg::cmd_t              cmd;
  dsq_pkg::link_t             head_lnk, tail_lnk;
  dsq_pkg::link_t             lnk [Depth];
  logic [Depth-1:0]           occ, tok_vec, stop_vec;
  logic                       accept, out_free, head_dec, stop_any, any_tok;
  logic                       head_exp;

  assign accept   = in_valid_i & ~in_stall_o;
  assign out_free = ~out_valid_q | ~out_stall_i;
  assign head_exp = (cnt_q != '0) && (lnk[0].dlt == '0);
  assign stop_any = |stop_vec;
  assign any_tok  = |tok_vec;

  // The head link starts a search at cell zero with the full sleep time.
  always_comb begin
    head_lnk     = '0;
    head_lnk.fwd = cmd.start;
    head_lnk.rnx = in_i.sleep_ticks;
  end
  assign tail_lnk = '0;

  // The row of cells. A cell is occupied when its position is below the fill
  // count, so unwritten positions never feed a result.
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    dsq_pkg::link_t left_l, right_l;

    assign occ[i]      = cnt_q > CntW'(i);
    assign tok_vec[i]  = lnk[i].tok;
    assign stop_vec[i] = lnk[i].tok & ~lnk[i].fwd;

    if (i == 0) begin : g_first
      assign left_l = head_lnk;
    end else begin : g_mid
      assign left_l = lnk[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_l = tail_lnk;
    end else begin : g_inner
      assign right_l = lnk[i+1];
    end

    dsq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .occ_i      (occ[i]),
      .head_dec_i ((i == 0) ? head_dec : 1'b0),
      .cmd_i      (cmd),
      .left_i     (left_l),
      .right_i    (right_l),
      .link_o     (lnk[i])
    );
  end

  // Sequencer. A tick that releases threads holds back the newest release until
  // the next one or the end of the pops, so that the final one can carry last.
  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ins_mode_d  = ins_mode_q;
    tid_d       = tid_q;
    kind_d      = kind_q;
    pend_v_d    = pend_v_q;
    pend_id_d   = pend_id_q;
    out_valid_d = out_valid_q & out_stall_i;
    out_d       = out_q;
    head_dec    = 1'b0;
    cmd         = '0;
    cmd.ins_mode = ins_mode_q;
    cmd.tid      = tid_q;

    case (state_q)
      SIdle: begin
        if (accept) begin
          tid_d = in_i.thread_id;
          case (in_i.func)
            dsq_pkg::FuncInsert: begin
              ins_mode_d = 1'b1;
              if (cnt_q == CntW'(Depth)) begin
                kind_d  = dsq_pkg::KindRefused;
                state_d = SResp;
              end else begin
                cmd.start = 1'b1;
                state_d   = SWalk;
              end
            end
            dsq_pkg::FuncTick: begin
              if (cnt_q != '0) begin
                head_dec = 1'b1;
                state_d  = SPop;
              end
            end
            dsq_pkg::FuncUnblock: begin
              ins_mode_d = 1'b0;
              cmd.start  = 1'b1;
              state_d    = SWalk;
            end
            default: ;
          endcase
        end
      end
      SWalk: begin
        if (stop_any && ins_mode_q) begin
          cmd.ins_go = 1'b1;
          cnt_d      = cnt_q + CntW'(1);
          kind_d     = dsq_pkg::KindAccepted;
          state_d    = SResp;
        end else if (stop_any || !any_tok) begin
          state_d = SIdle;
        end
      end
      SResp: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_d       = '{kind: kind_q, thread_id_res: tid_q, last: 1'b1};
          state_d     = SIdle;
        end
      end
      SPop: begin
        if (head_exp) begin
          if (!lnk[0].blk) begin
            cmd.pop = 1'b1;
            cnt_d   = cnt_q - CntW'(1);
          end else if (!pend_v_q || out_free) begin
            if (pend_v_q) begin
              out_valid_d = 1'b1;
              out_d = '{kind: dsq_pkg::KindReleased, thread_id_res: pend_id_q,
                        last: 1'b0};
            end
            pend_v_d  = 1'b1;
            pend_id_d = lnk[0].thr;
            cmd.pop   = 1'b1;
            cnt_d     = cnt_q - CntW'(1);
          end
        end else if (!pend_v_q) begin
          state_d = SIdle;
        end else if (out_free) begin
          out_valid_d = 1'b1;
          out_d = '{kind: dsq_pkg::KindReleased, thread_id_res: pend_id_q,
                    last: 1'b1};
          pend_v_d = 1'b0;
          state_d  = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= SIdle;
      cnt_q       <= '0;
      pend_v_q    <= 1'b0;
      out_valid_q <= 1'b0;
      ins_mode_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      pend_v_q    <= pend_v_d;
      out_valid_q <= out_valid_d;
      ins_mode_q  <= ins_mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tid_q     <= tid_d;
    kind_q    <= kind_d;
    pend_id_q <= pend_id_d;
    out_q     <= out_d;
  end

  assign in_stall_o  = state_q != SIdle;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  // The fill count never passes the number of cells.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(Depth))
    else $error("fill count exceeds depth");

  // At most one cell holds the search token.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(tok_vec))
    else $error("more than one search token");

  // An insert that finds its place grows the list by exactly one entry.
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins_go |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("insert did not grow the list");

  // A held-back release exists only while a tick is popping.
  a_pend_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_v_q |-> state_q == SPop)
    else $error("pending release outside of pop");

endmodule

// File: bench/tb_delta_sleep_queue.sv
// ----------------------------------------------------------------------------
// tb_delta_sleep_queue: self-checking bench for the delta sleep queue
// A driver offers insert, tick and unblock words from a backlog. An in-bench
// delta list predicts every released, accepted or refused thread. A monitor
// compares each result word against the oldest prediction, while both sides
// idle and stall at random rates.
// ----------------------------------------------------------------------------
module tb_delta_sleep_queue;
  timeunit 1ns;
  timeprecision 1ps;

  import dsq_pkg::*;

  localparam int unsigned Depth = DepthDef;

  // Function code that the block must ignore.
  localparam logic [1:0] FuncUnused = 2'd3;

  // Cycles without any accepted word before the run is declared hung. The
  // longest legal quiet stretch is the deliberate receiver hold-off.
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned QuietLimit = 3000;

  // Cycles allowed after the last expected result for silent work to settle.
  localparam int unsigned SettleCycles = 50;

  localparam int unsigned WordsPerPhase = 70;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_i        = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_o;

  delta_sleep_queue #(
    .Depth(Depth)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  always #5 clk_i = ~clk_i;

  // Words waiting to be offered, and results the list says must come out.
  in_word_t    word_backlog[$];
  out_word_t   pending_results[$];
  int unsigned words_queued = 0;
  int unsigned words_taken  = 0;
  int unsigned mismatches   = 0;

  // Idle and stall rates in percent, changed between phases.
  int unsigned idle_pct  = 0;
  int unsigned stall_pct = 0;

  // Long receiver hold-off, requested by the sequence and counted below.
  logic        hold_req  = 1'b0;
  int unsigned hold_left = 0;

  int unsigned quiet_cycles = 0;

  // Shadow copy of the delta list. Only positions below list_fill are valid.
  logic [TidW-1:0]   list_tid[Depth];
  logic [TicksW-1:0] list_dlt[Depth];
  logic              list_blk[Depth];
  int unsigned       list_fill = 0;

  // An insert walks from the head, spending each delta that is strictly
  // smaller than what is left of the sleep, and lands in front of the first
  // entry it cannot pass. That entry then loses what the new one now holds.
  function automatic void sleep_insert(logic [TidW-1:0] tid, logic [TicksW-1:0] ticks);
    logic [TicksW-1:0] rem;
    int unsigned       pos;
    int unsigned       i;
    out_word_t         res;
    res.thread_id_res = tid;
    res.last          = 1'b1;
    if (list_fill >= Depth) begin
      res.kind = KindRefused;
      pending_results.push_back(res);
      return;
    end
    rem = ticks;
    pos = 0;
    while (pos < list_fill && list_dlt[pos] < rem) begin
      rem -= list_dlt[pos];
      pos++;
    end
    for (i = list_fill; i > pos; i--) begin
      list_tid[i] = list_tid[i-1];
      list_dlt[i] = list_dlt[i-1];
      list_blk[i] = list_blk[i-1];
    end
    list_tid[pos] = tid;
    list_dlt[pos] = rem;
    list_blk[pos] = 1'b1;
    list_fill++;
    if (pos + 1 < list_fill) list_dlt[pos+1] -= rem;
    res.kind = KindAccepted;
    pending_results.push_back(res);
  endfunction

  // A tick takes one off the head delta without wrapping, then pops every
  // head at zero. Only entries still blocked are reported, and the last one
  // reported carries the last flag.
  function automatic void sleep_tick();
    out_word_t   freed[$];
    out_word_t   res;
    logic        blk;
    int unsigned i;
    if (list_fill == 0) return;
    if (list_dlt[0] != '0) list_dlt[0]--;
    while (list_fill > 0 && list_dlt[0] == '0) begin
      res.kind          = KindReleased;
      res.thread_id_res = list_tid[0];
      res.last          = 1'b0;
      blk               = list_blk[0];
      for (i = 1; i < list_fill; i++) begin
        list_tid[i-1] = list_tid[i];
        list_dlt[i-1] = list_dlt[i];
        list_blk[i-1] = list_blk[i];
      end
      list_fill--;
      if (blk) freed.push_back(res);
    end
    if (freed.size() != 0) freed[freed.size()-1].last = 1'b1;
    foreach (freed[k]) pending_results.push_back(freed[k]);
  endfunction

  // Only the first entry with the id loses its mark; duplicates keep theirs.
  function automatic void sleep_unblock(logic [TidW-1:0] tid);
    int unsigned i;
    for (i = 0; i < list_fill; i++) begin
      if (list_tid[i] == tid) begin
        list_blk[i] = 1'b0;
        break;
      end
    end
  endfunction

  function automatic void sleep_apply(in_word_t w);
    case (w.func)
      FuncInsert:  sleep_insert(w.thread_id, w.sleep_ticks);
      FuncTick:    sleep_tick();
      FuncUnblock: sleep_unblock(w.thread_id);
      default: ;
    endcase
  endfunction

  // Driver. A stalled word is held as it is; otherwise the next word from the
  // backlog goes out unless this cycle is drawn as an idle one. The list is
  // updated at the edge that accepts the word, and the first result of that
  // word can only be accepted at a later edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_i       <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        sleep_apply(in_i);
        words_taken++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (word_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_valid_i <= 1'b1;
          in_i       <= word_backlog.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Hold-off counter for the pressure phase. While it runs the receiver
  // stalls every cycle, so the output register fills and the block stops
  // taking new words even though the driver keeps offering them.
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left <= HoldCycles;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Receiver stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= (hold_left != 0) || ($urandom_range(99) < stall_pct);
    end
  end

  // Monitor. Every accepted result word must match the oldest prediction.
  always @(posedge clk_i) begin
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        $display("%0t: result with none expected: kind %0d id %0d last %0d",
                 $time, out_o.kind, out_o.thread_id_res, out_o.last);
      end else begin
        want = pending_results.pop_front();
        if (out_o.kind !== want.kind || out_o.thread_id_res !== want.thread_id_res ||
            out_o.last !== want.last) begin
          mismatches++;
          $display("%0t: expected kind %0d id %0d last %0d, got kind %0d id %0d last %0d",
                   $time, want.kind, want.thread_id_res, want.last,
                   out_o.kind, out_o.thread_id_res, out_o.last);
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves a word.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("%0t: no word moved for %0d cycles", $time, quiet_cycles);
        $display("FAILURE");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic queue_word(in_word_t w);
    word_backlog.push_back(w);
    words_queued++;
  endtask

  task automatic queue_op(logic [1:0] func, logic [TidW-1:0] tid, logic [TicksW-1:0] ticks);
    in_word_t w;
    w.func        = func;
    w.thread_id   = tid;
    w.sleep_ticks = ticks;
    queue_word(w);
  endtask

  // Random traffic. Most inserts use a small id pool and short sleeps so that
  // unblocks hit queued threads and ticks release them often; a few sleeps
  // are long or span the full range. Fields a word does not use still carry
  // random values, and a small share of words use the unused function code.
  task automatic queue_random(int unsigned count);
    int unsigned k;
    int unsigned pick;
    in_word_t    w;
    for (k = 0; k < count; k++) begin
      w.thread_id   = TidW'($urandom_range(255));
      w.sleep_ticks = TicksW'($urandom_range(65535));
      pick = $urandom_range(99);
      if (pick < 45) begin
        w.func = FuncInsert;
        if ($urandom_range(3) != 0) w.thread_id = TidW'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick >= 10) begin
          w.sleep_ticks = TicksW'($urandom_range(10));
        end else if (pick >= 3) begin
          w.sleep_ticks = TicksW'($urandom_range(40));
        end
      end else if (pick < 85) begin
        w.func = FuncTick;
      end else if (pick < 95) begin
        w.func = FuncUnblock;
        if ($urandom_range(3) != 0) w.thread_id = TidW'($urandom_range(15));
      end else begin
        w.func = FuncUnused;
      end
      queue_word(w);
    end
  endtask

  // Waits until every queued word is taken and every prediction has come out.
  task automatic wait_drained();
    while (words_taken != words_queued || pending_results.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Sequence. All changes to the backlog and the rates happen at falling
  // edges, away from the edges at which the driver and monitor act.
  initial begin
    int unsigned i;
    int unsigned phase;

    repeat (7) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed part. Empty tick, unblock with no match and the unused code
    // first; then zero and full-range sleeps with extreme ids, a zero sleep
    // that goes ahead of an equal zero, and a tick that meets a head already
    // at zero, drops an unblocked entry and releases the next one.
    queue_op(FuncTick, 8'h00, 16'h0000);
    queue_op(FuncUnblock, 8'h05, 16'h0000);
    queue_op(FuncUnused, 8'hFF, 16'hFFFF);
    queue_op(FuncInsert, 8'h00, 16'h0000);
    queue_op(FuncInsert, 8'hFF, 16'hFFFF);
    queue_op(FuncInsert, 8'hAA, 16'h0000);
    queue_op(FuncUnblock, 8'hAA, 16'h0000);
    queue_op(FuncTick, 8'h55, 16'h1234);
    // Fill the list to the brim; the last id repeats one already queued.
    for (i = 0; i < Depth - 1; i++) begin
      queue_op(FuncInsert, 8'((i + 1) * 17), 16'((i * 5) % 13));
    end
    // Full list refuses, then unblock hits the first of the two equal ids.
    queue_op(FuncInsert, 8'h5A, 16'h0003);
    queue_op(FuncUnblock, 8'hFF, 16'h0000);
    wait_drained();

    // Random phases: free flow, sender idling, receiver stalling, both, and
    // finally a long receiver hold-off while the sender keeps pushing.
    for (phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 67; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 67; end
        3: begin idle_pct = 22; stall_pct = 22; end
        default: begin idle_pct = 0; stall_pct = 0; end
      endcase
      if (phase == 4) hold_req = 1'b1;
      queue_random(WordsPerPhase);
      @(negedge clk_i);
      hold_req = 1'b0;
      wait_drained();
    end

    // Unblocks and empty ticks return nothing, so give the block time to
    // finish anything silent before the verdict.
    repeat (SettleCycles) @(negedge clk_i);

    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
